// ----- hdl/sbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types, constants and functions of the two-layer sprite blitter.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int LANES          = 8;
    localparam int PADDR_W        = 5;

    localparam logic [1:0] OP_BLIT1 = 2'd0;
    localparam logic [1:0] OP_BLIT2 = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RED    = 3'd2;
    localparam logic [2:0] REG_GREEN  = 3'd3;
    localparam logic [2:0] REG_BLUE   = 3'd4;

    localparam logic [9:0] SCREEN_RESET = 10'd512;

    typedef struct packed {
        logic [1:0]  operation;
        logic        layer_sel;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [3:0]  blend_mode;
        logic        flip_x;
        logic        flip_y;
        logic [63:0] plane_low;
        logic [63:0] plane_high;
    } t_req;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic        fg_redraw;
        logic        bg_redraw;
        logic        any_changed;
    } t_rsp;

    typedef struct packed {
        logic       valid;
        logic [1:0] color;
    } t_lane;

    localparam logic [1:0] BLEND [0:3][0:15] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
          2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
          2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
          2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
        '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
          2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
    };

    localparam logic [15:0] OPAQUE_ZERO = 16'b0111_1011_1101_1111;

    function automatic logic [7:0] doubled_nibble(input logic [15:0] levels,
                                                  input logic [1:0] color);
        logic [3:0] n;
        n = levels[(3 - color) * 4 +: 4];
        return {n, n};
    endfunction

endpackage

// ----- hdl/sbf_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_lane
// One sprite column: pixel value, blend lookup, transparency and clipping.
// ----------------------------------------------------------------------------
module sbf_lane #(
    parameter int LANE_IDX = 0,
    parameter int XW       = 9,
    parameter int EW       = 10
) (
    input  logic          i_lo_bit,
    input  logic          i_hi_bit,
    input  logic          i_two_bpp,
    input  logic [3:0]    i_mode,
    input  logic          i_flip_x,
    input  logic [15:0]   i_pos_x,
    input  logic [EW-1:0] i_eff_w,
    output sbf_pkg::t_lane o_lane,
    output logic [XW-1:0] o_x
);
    logic [1:0]  ch;
    logic [2:0]  off;
    logic [15:0] x;

    always_comb begin
        ch  = {i_two_bpp & i_hi_bit, i_lo_bit};
        off = i_flip_x ? 3'(sbf_pkg::LANES - 1 - LANE_IDX) : 3'(LANE_IDX);
        x   = i_pos_x + 16'(off);
        o_lane.color = sbf_pkg::BLEND[ch][i_mode];
        o_lane.valid = ((ch != 2'd0) || sbf_pkg::OPAQUE_ZERO[i_mode]) &&
                       (32'(x) < 32'(i_eff_w));
        o_x = x[XW-1:0];
    end
endmodule

// ----- hdl/sbf_layer_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_layer_mem
// One layer of 2-bit pixels with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sbf_layer_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);
    logic [1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/sprite_blit_two_layer_framebuffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_blit_two_layer_framebuffer_top
// Two-layer 2-bit framebuffer with an 8x8 sprite blitter and palette read.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_ready  sbf_pkg::t_req
//   out      output     o_out_valid / i_out_ready sbf_pkg::t_rsp
//   config   input      APB psel/penable/pready  five registers
//
// A blit works row by row: per sprite row a state for the row address multiply,
// then a read-compare-write on the layer memory for each of its eight pixels,
// and a drain and a finish state at the end. A read passes the row, read address,
// read data and finish states; a flag clear only the finish state.
// One request at a time. After reset both layers are cleared, one pixel a cycle,
// over MAX_WIDTH*MAX_HEIGHT pixels (262144 by default) before the first request.
// While one result waits in the output register the next request is still
// processed; its result then waits in the finish state and holds the input.
// ----------------------------------------------------------------------------
module sprite_blit_two_layer_framebuffer_top #(
    parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sbf_pkg::t_req               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sbf_pkg::t_rsp               o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ROW, S_PIX, S_DRAIN, S_RD_ADDR, S_RD_DATA, S_FIN
    } t_state;

    t_state         r_state;
    sbf_pkg::t_req  r_item;
    logic [9:0]     r_width;
    logic [9:0]     r_height;
    logic [15:0]    r_red;
    logic [15:0]    r_green;
    logic [15:0]    r_blue;
    logic [AW-1:0]  r_clr_addr;
    logic [2:0]     r_v;
    logic [2:0]     r_hc;
    logic [AW-1:0]  r_row_base;
    logic           r_y_ok;
    logic           r_p_valid;
    logic [AW-1:0]  r_p_addr;
    logic [1:0]     r_p_color;
    logic           r_rd_ok;
    logic           r_changed;
    logic           r_fg_dirty;
    logic           r_bg_dirty;
    logic [23:0]    r_rgb;
    logic           r_out_valid;
    sbf_pkg::t_rsp  r_out;

    logic [EW-1:0]  eff_w;
    logic [HW-1:0]  eff_h;
    logic           in_fire;
    logic           cfg_wr;
    logic [7:0]     lo_row;
    logic [7:0]     hi_row;
    sbf_pkg::t_lane lanes [0:sbf_pkg::LANES-1];
    logic [XW-1:0]  lane_x [0:sbf_pkg::LANES-1];
    logic [2:0]     v_off;
    logic [15:0]    y;
    logic [XW-1:0]  sel_x;
    logic [AW-1:0]  raddr;
    logic [1:0]     fg_rd;
    logic [1:0]     bg_rd;
    logic [1:0]     cur_rd;
    logic           pix_wr;
    logic           fg_we;
    logic           bg_we;
    logic [AW-1:0]  waddr;
    logic [1:0]     wdata;
    logic [1:0]     comp;

    assign eff_w = ({22'd0, r_width} > 32'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(r_width);
    assign eff_h = ({22'd0, r_height} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(r_height);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            sbf_pkg::REG_WIDTH:  prdata = {22'd0, r_width};
            sbf_pkg::REG_HEIGHT: prdata = {22'd0, r_height};
            sbf_pkg::REG_RED:    prdata = {16'd0, r_red};
            sbf_pkg::REG_GREEN:  prdata = {16'd0, r_green};
            sbf_pkg::REG_BLUE:   prdata = {16'd0, r_blue};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sbf_pkg::SCREEN_RESET;
            r_height <= sbf_pkg::SCREEN_RESET;
            r_red    <= 16'd0;
            r_green  <= 16'd0;
            r_blue   <= 16'd0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                sbf_pkg::REG_WIDTH:  r_width  <= pwdata[9:0];
                sbf_pkg::REG_HEIGHT: r_height <= pwdata[9:0];
                sbf_pkg::REG_RED:    r_red    <= pwdata[15:0];
                sbf_pkg::REG_GREEN:  r_green  <= pwdata[15:0];
                sbf_pkg::REG_BLUE:   r_blue   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign lo_row = r_item.plane_low[(7 - r_v) * 8 +: 8];
    assign hi_row = r_item.plane_high[(7 - r_v) * 8 +: 8];

    for (genvar i = 0; i < sbf_pkg::LANES; i++) begin : g_lane
        sbf_lane #(
            .LANE_IDX (i),
            .XW       (XW),
            .EW       (EW)
        ) u_lane (
            .i_lo_bit  (lo_row[sbf_pkg::LANES - 1 - i]),
            .i_hi_bit  (hi_row[sbf_pkg::LANES - 1 - i]),
            .i_two_bpp (r_item.operation == sbf_pkg::OP_BLIT2),
            .i_mode    (r_item.blend_mode),
            .i_flip_x  (r_item.flip_x),
            .i_pos_x   (r_item.pos_x),
            .i_eff_w   (eff_w),
            .o_lane    (lanes[i]),
            .o_x       (lane_x[i])
        );
    end

    always_comb begin
        if (r_item.operation == sbf_pkg::OP_READ) begin
            v_off = 3'd0;
        end else begin
            v_off = r_item.flip_y ? (3'd7 - r_v) : r_v;
        end
        y      = r_item.pos_y + 16'(v_off);
        sel_x  = (r_state == S_RD_ADDR) ? r_item.pos_x[XW-1:0] : lane_x[r_hc];
        raddr  = r_row_base + AW'(sel_x);
        cur_rd = r_item.layer_sel ? fg_rd : bg_rd;
        pix_wr = r_p_valid && (cur_rd != r_p_color);
        comp   = (fg_rd != 2'd0) ? fg_rd : bg_rd;
        if (r_state == S_CLEAR) begin
            waddr = r_clr_addr;
            wdata = 2'd0;
            fg_we = 1'b1;
            bg_we = 1'b1;
        end else begin
            waddr = r_p_addr;
            wdata = r_p_color;
            fg_we = pix_wr && r_item.layer_sel;
            bg_we = pix_wr && !r_item.layer_sel;
        end
    end

    sbf_layer_mem #(.DEPTH(DEPTH), .AW(AW)) u_fg_mem (
        .i_clk   (i_clk),
        .i_we    (fg_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (fg_rd)
    );

    sbf_layer_mem #(.DEPTH(DEPTH), .AW(AW)) u_bg_mem (
        .i_clk   (i_clk),
        .i_we    (bg_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (bg_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_v         <= 3'd0;
            r_hc        <= 3'd0;
            r_p_valid   <= 1'b0;
            r_changed   <= 1'b0;
            r_fg_dirty  <= 1'b0;
            r_bg_dirty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_p_valid <= (r_state == S_PIX) && r_y_ok && lanes[r_hc].valid;
            r_p_addr  <= raddr;
            r_p_color <= lanes[r_hc].color;
            if (pix_wr) begin
                r_changed <= 1'b1;
                if (r_item.layer_sel) begin
                    r_fg_dirty <= 1'b1;
                end else begin
                    r_bg_dirty <= 1'b1;
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_item    <= i_in;
                        r_v       <= 3'd0;
                        r_hc      <= 3'd0;
                        r_changed <= 1'b0;
                        r_rgb     <= 24'd0;
                        if (i_in.operation == sbf_pkg::OP_CLEAR) begin
                            r_fg_dirty <= 1'b0;
                            r_bg_dirty <= 1'b0;
                            r_state    <= S_FIN;
                        end else begin
                            r_state <= S_ROW;
                        end
                    end
                end
                S_ROW: begin
                    r_y_ok     <= 32'(y) < 32'(eff_h);
                    r_row_base <= AW'(y[YW-1:0] * eff_w);
                    r_state    <= (r_item.operation == sbf_pkg::OP_READ) ? S_RD_ADDR : S_PIX;
                end
                S_PIX: begin
                    r_hc <= r_hc + 3'd1;
                    if (r_hc == 3'd7) begin
                        r_v     <= r_v + 3'd1;
                        r_state <= (r_v == 3'd7) ? S_DRAIN : S_ROW;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_RD_ADDR: begin
                    r_rd_ok <= r_y_ok && (32'(r_item.pos_x) < 32'(eff_w));
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    if (r_rd_ok) begin
                        r_rgb <= {sbf_pkg::doubled_nibble(r_red, comp),
                                  sbf_pkg::doubled_nibble(r_green, comp),
                                  sbf_pkg::doubled_nibble(r_blue, comp)};
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid       <= 1'b1;
                        r_out.pixel_rgb   <= r_rgb;
                        r_out.fg_redraw   <= r_fg_dirty;
                        r_out.bg_redraw   <= r_bg_dirty;
                        r_out.any_changed <= r_changed;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(fg_we || bg_we))
        else $error("Layer written while idle.");

    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_p_valid)
        else $error("Pixel write pending while accepting a request.");

    a_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.operation == sbf_pkg::OP_CLEAR) |=> (!r_fg_dirty && !r_bg_dirty))
        else $error("Redraw flags not cleared.");

endmodule
